// ----- rtl/ktr_pkg.sv -----
// Shared constants for the keyword token redactor: keywords, their lengths,
// character codes and the terminator test. No dependencies.
`timescale 1ns / 1ps

package ktr_pkg;

   localparam int NUM_STAGES = 6;
   localparam int KW_MAX     = 23;
   localparam int BYTE_W     = 8;
   localparam int CNT_W      = 5;

   typedef logic [BYTE_W-1:0]        byte_type;
   typedef logic [KW_MAX*BYTE_W-1:0] kw_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   // one byte and its end-of-line mark, as handed from cell to cell
   typedef struct packed {
      logic     last;
      byte_type data;
   } beat_type;

   localparam cnt_type  CNT_SAT = '1;

   localparam byte_type CH_X     = 8'h78;   // 'x'
   localparam byte_type CH_AMP   = 8'h26;
   localparam byte_type CH_DQUOT = 8'h22;
   localparam byte_type CH_SQUOT = 8'h27;
   localparam byte_type CH_SPACE = 8'h20;
   localparam byte_type CH_TAB   = 8'h09;
   localparam byte_type CH_CR    = 8'h0D;
   localparam byte_type CH_LF    = 8'h0A;
   localparam byte_type CH_SEMI  = 8'h3B;
   localparam byte_type CH_LT    = 8'h3C;
   localparam byte_type CH_GT    = 8'h3E;

   // keywords right-aligned: the last character sits in the low byte
   localparam kw_type KW_TEXT [NUM_STAGES] = '{
      kw_type'("api_key="),
      kw_type'({"X-Media", "Browser-Token%3D"}),
      kw_type'({"X-Media", "Browser-Token="}),
      kw_type'("ApiKey="),
      kw_type'("AccessToken="),
      kw_type'("AccessToken\":\"")
   };

   localparam int KW_LEN [NUM_STAGES] = '{8, 23, 21, 7, 12, 14};

   // last stage stops only at a double quote
   localparam logic QUOTE_ONLY [NUM_STAGES] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   function automatic logic is_term(input logic quote_only, input byte_type b);
      logic hit;
      begin
         if (quote_only) begin
            hit = (b == CH_DQUOT);
         end else begin
            case (b) inside
               CH_AMP, CH_DQUOT, CH_SQUOT, CH_SPACE, CH_TAB,
               CH_CR, CH_LF, CH_SEMI, CH_LT, CH_GT: hit = 1'b1;
               default: hit = 1'b0;
            endcase
         end
         return hit;
      end
   endfunction

endpackage

// ----- rtl/ktr_cell.sv -----
// One rule cell: keyword window, restart counter and redact flag, with an
// output register that feeds the next cell. Depends on ktr_pkg.
`timescale 1ns / 1ps

module ktr_cell #(
   parameter int STAGE_IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ktr_pkg::beat_type in_beat,
   output logic              in_ready,
   output logic              out_valid,
   output ktr_pkg::beat_type out_beat,
   input  logic              out_ready
);

   localparam int KwLen = ktr_pkg::KW_LEN[STAGE_IDX];
   localparam int HistW = KwLen * ktr_pkg::BYTE_W;
   localparam ktr_pkg::kw_type KwText = ktr_pkg::KW_TEXT[STAGE_IDX];
   localparam logic QuoteOnly = ktr_pkg::QUOTE_ONLY[STAGE_IDX];
   localparam ktr_pkg::cnt_type KwLenCnt = ktr_pkg::cnt_type'(KwLen);

   logic              valid_ff, valid_in;
   ktr_pkg::beat_type beat_ff, beat_in;
   logic [HistW-1:0]  hist_ff, hist_in;
   ktr_pkg::cnt_type  cnt_ff, cnt_in;
   logic              red_ff, red_in;

   logic              take;
   logic              term;
   logic              match;
   ktr_pkg::cnt_type  cnt_base;
   ktr_pkg::cnt_type  cnt_inc;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      term     = ktr_pkg::is_term(QuoteOnly, in_beat.data);
      hist_in  = {hist_ff[HistW-ktr_pkg::BYTE_W-1:0], in_beat.data};
      cnt_base = red_ff ? '0 : cnt_ff;
      cnt_inc  = (cnt_base != ktr_pkg::CNT_SAT) ? cnt_base + ktr_pkg::cnt_type'(1) : cnt_base;
      match    = (cnt_inc >= KwLenCnt) && (hist_in == KwText[HistW-1:0]);

      valid_in = in_ready ? in_valid : valid_ff;
      beat_in  = beat_ff;
      cnt_in   = cnt_ff;
      red_in   = red_ff;
      if (take) begin
         beat_in.last = in_beat.last;
         if (red_ff && !term) begin
            beat_in.data = ktr_pkg::CH_X;
         end else begin
            beat_in.data = in_beat.data;
            red_in       = match;
            cnt_in       = match ? '0 : cnt_inc;
         end
         // line end restarts the search
         if (in_beat.last) begin
            cnt_in = '0;
            red_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         red_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         red_ff   <= red_in;
      end
      beat_ff <= beat_in;
      if (take) begin
         hist_ff <= hist_in;
      end
   end

   // counter sits at zero for the whole token
   a_red_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      red_ff |-> (cnt_ff == '0))
      else $error("redacting with nonzero restart count");

   a_line_end_clear: assert property (@(posedge clock) disable iff (reset)
      (take && in_beat.last) |=> (!red_ff && (cnt_ff == '0)))
      else $error("matcher state survived a line end");

   a_redact_x: assert property (@(posedge clock) disable iff (reset)
      (take && red_ff && !term) |=> (beat_ff.data == ktr_pkg::CH_X))
      else $error("token byte not replaced");

endmodule

// ----- rtl/keyword_token_redactor.sv -----
// Top level of the keyword token redactor: a chain of six rule cells
// between a request and a response stream. Depends on ktr_pkg, ktr_cell.
`timescale 1ns / 1ps

// One register per rule cell; each cell compares its window once a byte.
// The chain takes one byte per cycle while the response is not stalled.
// Ready runs back through the cells, so empty cells keep filling while the
// response waits. Reset (synchronous, active high) empties the chain and
// clears every matcher.
module keyword_token_redactor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // line_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_line_end
);

   localparam int N = ktr_pkg::NUM_STAGES;

   logic              valid [N+1];
   logic              ready [N+1];
   ktr_pkg::beat_type beat  [N+1];

   assign valid[0]     = req_tvalid;
   assign beat[0].data = req_tdata;
   assign beat[0].last = req_tlast;
   assign req_tready   = ready[0];

   for (genvar s = 0; s < N; s++) begin : g_cell
      ktr_cell #(
         .STAGE_IDX (s)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[s]),
         .in_beat   (beat[s]),
         .in_ready  (ready[s]),
         .out_valid (valid[s+1]),
         .out_beat  (beat[s+1]),
         .out_ready (ready[s+1])
      );
   end

   assign ready[N]   = rsp_tready;
   assign rsp_tvalid = valid[N];
   assign rsp_tdata  = beat[N].data;
   assign rsp_tlast  = beat[N].last;

   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output drains");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule
